// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the row deframer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nlrd_pkg.sv =====
// ---------------------------------------------------------------------------
// nlrd_pkg
// Types and constants shared by the row deframer front, queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none

package nlrd_pkg;

  // Group header size in bytes (first four bytes hold the body size)
  localparam int unsigned HEADER_BYTES = 9;
  localparam int unsigned FCNT_W       = 6;

  // Request queue between front and back end
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NEG_SIZE  = 3'd1,
    ERR_LEN_CROSS = 3'd2,
    ERR_ROW_OVER  = 3'd3,
    ERR_TRUNC     = 3'd4
  } err_t;

  // One queued request: an optional main result plus an optional
  // truncation error that follows it
  typedef struct packed {
    logic        main_v;
    logic        trail_v;
    logic        page_end;
    kind_t       kind;
    logic [7:0]  payload;
    logic        row_first;
    logic        row_last;
    logic [31:0] row_length;
    logic [31:0] row_offset;
    err_t        error_code;
  } q_entry_t;

  // Queue status seen by the front and back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One result as it leaves the block
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic        row_first;
    logic        row_last;
    logic [31:0] row_length;
    logic [31:0] row_offset;
    err_t        error_code;
    logic        page_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/nlrd_front.sv =====
// ---------------------------------------------------------------------------
// nlrd_front
// Byte parser: tracks group headers, row length fields and payload, and
// turns each accepted byte into at most one queued request.
// ---------------------------------------------------------------------------
`default_nettype none

module nlrd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              page_end_i,
  output nlrd_pkg::q_entry_t     entry_o,
  output logic                   push_o
);

  `include "assert_macros.svh"

  nlrd_pkg::phase_t                    phase_r, phase_nxt;
  logic [nlrd_pkg::FCNT_W-1:0]         fcnt_r, fcnt_nxt;
  logic [31:0]                         acc_r, acc_nxt;
  logic [31:0]                         grp_left_r, grp_left_nxt;
  logic [31:0]                         row_left_r, row_left_nxt;
  logic [31:0]                         row_len_r, row_len_nxt;
  logic [31:0]                         page_off_r, page_off_nxt;
  logic [31:0]                         row_start_r, row_start_nxt;

  // shared per-byte terms
  logic [nlrd_pkg::FCNT_W-1:0] fcnt_inc;
  logic                        hdr_done;
  logic [31:0]                 hdr_acc;
  logic [31:0]                 len_shift;
  logic [31:0]                 grp_dec;
  logic [31:0]                 start_off;
  logic                        len_short;
  logic                        len_done;
  logic                        len_over;
  logic                        errored;
  logic                        clean_end;
  nlrd_pkg::phase_t            phase_step;
  logic [nlrd_pkg::FCNT_W-1:0] fcnt_step;

  assign fcnt_inc  = fcnt_r + nlrd_pkg::FCNT_W'(1);
  assign hdr_done  = (fcnt_inc >= nlrd_pkg::FCNT_W'(nlrd_pkg::HEADER_BYTES));
  // group size with this byte merged in (little-endian, first four bytes)
  assign hdr_acc   = (fcnt_r < nlrd_pkg::FCNT_W'(4)) ?
                     (acc_r | (32'(data_byte_i) << {fcnt_r[1:0], 3'b000})) : acc_r;
  assign len_shift = {acc_r[23:0], data_byte_i};
  assign grp_dec   = grp_left_r - 32'd1;
  assign start_off = page_off_r + 32'd1;
  assign len_short = (fcnt_r == '0) && (grp_left_r < 32'd4);
  assign len_done  = (fcnt_r == nlrd_pkg::FCNT_W'(3));
  assign len_over  = (len_shift > grp_dec);

  // Next-state and datapath update for one byte
  always_comb begin
    phase_step    = phase_r;
    fcnt_step     = fcnt_r;
    acc_nxt       = acc_r;
    grp_left_nxt  = grp_left_r;
    row_left_nxt  = row_left_r;
    row_len_nxt   = row_len_r;
    row_start_nxt = row_start_r;
    errored       = 1'b0;
    case (phase_r)
      nlrd_pkg::PH_HEADER: begin
        acc_nxt   = hdr_acc;
        fcnt_step = fcnt_inc;
        if (hdr_done) begin
          fcnt_step = '0;
          acc_nxt   = '0;
          if (hdr_acc[31]) begin
            errored    = 1'b1;
            phase_step = nlrd_pkg::PH_DISCARD;
          end else if (hdr_acc != '0) begin
            grp_left_nxt = hdr_acc;
            phase_step   = nlrd_pkg::PH_LENGTH;
          end
        end
      end
      nlrd_pkg::PH_LENGTH: begin
        if (len_short) begin
          errored    = 1'b1;
          phase_step = nlrd_pkg::PH_DISCARD;
        end else begin
          acc_nxt      = len_shift;
          grp_left_nxt = grp_dec;
          fcnt_step    = fcnt_inc;
          if (len_done) begin
            fcnt_step = '0;
            acc_nxt   = '0;
            if (len_over) begin
              errored    = 1'b1;
              phase_step = nlrd_pkg::PH_DISCARD;
            end else if (len_shift == '0) begin
              if (grp_dec == '0) begin
                phase_step = nlrd_pkg::PH_HEADER;
              end
            end else begin
              row_len_nxt   = len_shift;
              row_left_nxt  = len_shift;
              row_start_nxt = start_off;
              phase_step    = nlrd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      nlrd_pkg::PH_PAYLOAD: begin
        row_left_nxt = row_left_r - 32'd1;
        grp_left_nxt = grp_dec;
        if (row_left_r == 32'd1) begin
          phase_step = (grp_dec == '0) ? nlrd_pkg::PH_HEADER : nlrd_pkg::PH_LENGTH;
        end
      end
      nlrd_pkg::PH_DISCARD: begin
        phase_step = nlrd_pkg::PH_DISCARD;
      end
      default: begin
        phase_step = nlrd_pkg::PH_DISCARD;
      end
    endcase

    clean_end = ((phase_step == nlrd_pkg::PH_HEADER) && (fcnt_step == '0)) ||
                (phase_step == nlrd_pkg::PH_DISCARD);

    // page end returns everything to its reset values
    phase_nxt    = phase_step;
    fcnt_nxt     = fcnt_step;
    page_off_nxt = start_off;
    if (page_end_i) begin
      phase_nxt     = nlrd_pkg::PH_HEADER;
      fcnt_nxt      = '0;
      acc_nxt       = '0;
      grp_left_nxt  = '0;
      row_left_nxt  = '0;
      row_len_nxt   = '0;
      page_off_nxt  = '0;
      row_start_nxt = '0;
    end
  end

  // Request built from the current byte
  always_comb begin
    entry_o            = '0;
    entry_o.kind       = nlrd_pkg::KIND_DATA;
    entry_o.error_code = nlrd_pkg::ERR_NONE;
    entry_o.page_end   = page_end_i;
    case (phase_r)
      nlrd_pkg::PH_HEADER: begin
        if (hdr_done && hdr_acc[31]) begin
          entry_o.main_v     = 1'b1;
          entry_o.kind       = nlrd_pkg::KIND_ERROR;
          entry_o.error_code = nlrd_pkg::ERR_NEG_SIZE;
        end
      end
      nlrd_pkg::PH_LENGTH: begin
        if (len_short) begin
          entry_o.main_v     = 1'b1;
          entry_o.kind       = nlrd_pkg::KIND_ERROR;
          entry_o.error_code = nlrd_pkg::ERR_LEN_CROSS;
        end else if (len_done && len_over) begin
          entry_o.main_v     = 1'b1;
          entry_o.kind       = nlrd_pkg::KIND_ERROR;
          entry_o.error_code = nlrd_pkg::ERR_ROW_OVER;
        end else if (len_done && (len_shift == '0)) begin
          entry_o.main_v     = 1'b1;
          entry_o.kind       = nlrd_pkg::KIND_EMPTY;
          entry_o.row_offset = start_off;
        end
      end
      nlrd_pkg::PH_PAYLOAD: begin
        entry_o.main_v     = 1'b1;
        entry_o.kind       = nlrd_pkg::KIND_DATA;
        entry_o.payload    = data_byte_i;
        entry_o.row_first  = (row_left_r == row_len_r);
        entry_o.row_last   = (row_left_r == 32'd1);
        entry_o.row_length = row_len_r;
        entry_o.row_offset = row_start_r;
      end
      default: begin
        entry_o.main_v = 1'b0;
      end
    endcase
    // truncation error follows whatever this byte produced
    entry_o.trail_v = page_end_i && !clean_end && !errored;
  end

  assign push_o = accept_i && (entry_o.main_v || entry_o.trail_v);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nlrd_pkg::PH_HEADER;
      fcnt_r      <= '0;
      acc_r       <= '0;
      grp_left_r  <= '0;
      row_left_r  <= '0;
      row_len_r   <= '0;
      page_off_r  <= '0;
      row_start_r <= '0;
    end else if (accept_i) begin
      phase_r     <= phase_nxt;
      fcnt_r      <= fcnt_nxt;
      acc_r       <= acc_nxt;
      grp_left_r  <= grp_left_nxt;
      row_left_r  <= row_left_nxt;
      row_len_r   <= row_len_nxt;
      page_off_r  <= page_off_nxt;
      row_start_r <= row_start_nxt;
    end
  end

  // Checks
  `ASSERT_IMPL(a_len_fcnt, phase_r == nlrd_pkg::PH_LENGTH, fcnt_r < nlrd_pkg::FCNT_W'(4),
    "length field count out of range")
  `ASSERT_IMPL(a_payload_rows, phase_r == nlrd_pkg::PH_PAYLOAD,
    (row_left_r != '0) && (row_left_r <= row_len_r), "payload row count out of range")

endmodule

`default_nettype wire

// ===== rtl/nlrd_queue.sv =====
// ---------------------------------------------------------------------------
// nlrd_queue
// Short request queue that decouples the byte parser from the result stage.
// ---------------------------------------------------------------------------
`default_nettype none

module nlrd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_i,
  input  wire nlrd_pkg::q_entry_t entry_i,
  input  wire logic               pop_i,
  output nlrd_pkg::q_entry_t      head_o,
  output nlrd_pkg::q_stat_t       stat_o
);

  `include "assert_macros.svh"

  nlrd_pkg::q_entry_t               mem_r [nlrd_pkg::QUEUE_DEPTH];
  logic [nlrd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [nlrd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [nlrd_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.full  = (count_r == nlrd_pkg::QCNT_W'(nlrd_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_r == '0);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == nlrd_pkg::QPTR_W'(nlrd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + nlrd_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == nlrd_pkg::QPTR_W'(nlrd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + nlrd_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + nlrd_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - nlrd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  // Checks
  `ASSERT_ALWAYS(a_count_bound, count_r <= nlrd_pkg::QCNT_W'(nlrd_pkg::QUEUE_DEPTH),
    "queue count above depth")
  `ASSERT_IMPL(a_no_overflow, push_i, !stat_o.full, "push into full queue")
  `ASSERT_IMPL(a_no_underflow, pop_i, !stat_o.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== rtl/nlrd_back.sv =====
// ---------------------------------------------------------------------------
// nlrd_back
// Result stage: expands each queued request into one or two results and
// holds them in an output register until the sink takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module nlrd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire nlrd_pkg::q_entry_t head_i,
  input  wire nlrd_pkg::q_stat_t  stat_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output nlrd_pkg::result_t       out_res_o
);

  `include "assert_macros.svh"

  logic                 out_valid_r, out_valid_nxt;
  logic                 sent_main_r, sent_main_nxt;
  nlrd_pkg::result_t    res_r, res_nxt;
  logic                 load;
  logic                 take_main;

  assign load      = !stat_i.empty && (!out_valid_r || out_ready_i);
  assign take_main = head_i.main_v && !sent_main_r;

  // Pick the main result first, then the trailing truncation error
  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    sent_main_nxt = sent_main_r;
    pop_o         = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (take_main) begin
        res_nxt.kind       = head_i.kind;
        res_nxt.payload    = head_i.payload;
        res_nxt.row_first  = head_i.row_first;
        res_nxt.row_last   = head_i.row_last;
        res_nxt.row_length = head_i.row_length;
        res_nxt.row_offset = head_i.row_offset;
        res_nxt.error_code = head_i.error_code;
        res_nxt.page_done  = head_i.page_end && !head_i.trail_v;
        if (head_i.trail_v) begin
          sent_main_nxt = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        res_nxt            = '0;
        res_nxt.kind       = nlrd_pkg::KIND_ERROR;
        res_nxt.error_code = nlrd_pkg::ERR_TRUNC;
        res_nxt.page_done  = head_i.page_end;
        sent_main_nxt      = 1'b0;
        pop_o              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_main_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_main_r <= sent_main_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = res_r;

  // Checks
  `ASSERT_IMPL(a_half_has_entry, sent_main_r, !stat_i.empty && head_i.trail_v,
    "split request lost its queue entry")
  `ASSERT_NEXT(a_split_order, load && take_main && head_i.trail_v, sent_main_r,
    "main result not followed by its truncation error")

endmodule

`default_nettype wire

// ===== rtl/nested_length_prefixed_row_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// nested_length_prefixed_row_deframer_unit
// Splits a byte page into row groups and rows and streams out each payload
// byte tagged with its row's length and offset, plus empty-row and error
// results.
//
//   Channel  Dir  tdata                               tuser / tlast
//   in_      in   data_byte[7:0]                      tlast: page_end
//   out_     out  payload, row_length, row_offset,    tuser: kind, row_first,
//                 error_code                          row_last; tlast: page_done
//
// One input byte is accepted per cycle while in_tready is high; the parser
// settles each byte in the cycle it is taken. Results leave one per cycle
// while out_tready is high; a page end mid-structure adds a truncation error
// after the byte's own result, if any. A four-entry request queue plus the
// output register absorb output stalls; in_tready drops only on a full queue.
// Reset (rst_n low, synchronous) clears parser state, queue and output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module nested_length_prefixed_row_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // page_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] payload, [39:8] row_length,
                                       // [71:40] row_offset, [74:72] error_code,
                                       // [79:75] zero
  output logic [3:0]       out_tuser,  // [1:0] kind, [2] row_first, [3] row_last
  output logic             out_tlast   // page_done
);

  nlrd_pkg::q_entry_t  f_entry;
  nlrd_pkg::q_entry_t  q_head;
  nlrd_pkg::q_stat_t   q_stat;
  nlrd_pkg::result_t   res;
  logic                accept;
  logic                push;
  logic                pop;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Byte parser
  nlrd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .data_byte_i (in_tdata),
    .page_end_i  (in_tlast),
    .entry_o     (f_entry),
    .push_o      (push)
  );

  // Request queue
  nlrd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // Result stage
  nlrd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_i      (q_head),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  // Output packing
  assign out_tdata = {5'd0, res.error_code, res.row_offset, res.row_length, res.payload};
  assign out_tuser = {res.row_last, res.row_first, res.kind};
  assign out_tlast = res.page_done;

endmodule

`default_nettype wire

// ===== tb/tb_nested_length_prefixed_row_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_nested_length_prefixed_row_deframer_unit
// Self-checking bench for the row deframer. Pages of row groups, well formed
// and broken, are streamed in with bursty input and a stalling receiver. Each
// accepted byte runs through a local deframer model that queues the results
// it must produce, and every result request leaving the block is compared
// field by field against the oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nested_length_prefixed_row_deframer_unit;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // page_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;   // [7:0] payload, [39:8] row_length, [71:40] row_offset,
                            // [74:72] error_code, [79:75] zero
  logic [3:0]  out_tuser;   // [1:0] kind, [2] row_first, [3] row_last
  logic        out_tlast;   // page_done

  nested_length_prefixed_row_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Deframer model state
  nlrd_pkg::phase_t ph;
  logic [5:0]  fcnt;
  logic [31:0] acc;
  logic [31:0] grp_left;
  logic [31:0] row_left;
  logic [31:0] row_len;
  logic [31:0] page_off;
  logic [31:0] row_start;

  nlrd_pkg::result_t due_results[$];
  logic [7:0]  page_buf[$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_tick = 0;
  int          cycles = 0;
  nlrd_pkg::result_t want;

  function automatic nlrd_pkg::result_t make_result(nlrd_pkg::kind_t k, logic [7:0] p,
                                                    logic f, logic l, logic [31:0] len,
                                                    logic [31:0] off, nlrd_pkg::err_t e);
    nlrd_pkg::result_t r;
    r.kind       = k;
    r.payload    = p;
    r.row_first  = f;
    r.row_last   = l;
    r.row_length = len;
    r.row_offset = off;
    r.error_code = e;
    r.page_done  = 1'b0;
    return r;
  endfunction

  task automatic reset_deframer();
    ph        = nlrd_pkg::PH_HEADER;
    fcnt      = '0;
    acc       = '0;
    grp_left  = '0;
    row_left  = '0;
    row_len   = '0;
    page_off  = '0;
    row_start = '0;
  endtask

  // Advance the model by one byte and queue the results it causes
  task automatic deframe_byte(input logic [7:0] b, input logic is_last);
    nlrd_pkg::result_t outs[2];
    int          n;
    logic        errd;
    logic        clean;
    logic [31:0] len;
    logic [31:0] start;
    n    = 0;
    errd = 1'b0;
    case (ph)
      nlrd_pkg::PH_HEADER: begin
        if (fcnt < 4) acc = acc | (32'(b) << (8 * fcnt));
        fcnt = fcnt + 6'd1;
        if (fcnt >= nlrd_pkg::HEADER_BYTES) begin
          fcnt = '0;
          if (acc[31]) begin
            outs[n] = make_result(nlrd_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, 32'd0, 32'd0,
                                  nlrd_pkg::ERR_NEG_SIZE);
            n = n + 1;
            errd = 1'b1;
            ph = nlrd_pkg::PH_DISCARD;
          end else if (acc != 0) begin
            grp_left = acc;
            ph = nlrd_pkg::PH_LENGTH;
          end
          acc = '0;
        end
      end
      nlrd_pkg::PH_LENGTH: begin
        if (fcnt == 0 && grp_left < 4) begin
          outs[n] = make_result(nlrd_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, 32'd0, 32'd0,
                                nlrd_pkg::ERR_LEN_CROSS);
          n = n + 1;
          errd = 1'b1;
          ph = nlrd_pkg::PH_DISCARD;
        end else begin
          acc = {acc[23:0], b};
          grp_left = grp_left - 1;
          fcnt = fcnt + 6'd1;
          if (fcnt >= 4) begin
            len   = acc;
            start = page_off + 1;
            fcnt  = '0;
            acc   = '0;
            if (len > grp_left) begin
              outs[n] = make_result(nlrd_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, 32'd0, 32'd0,
                                    nlrd_pkg::ERR_ROW_OVER);
              n = n + 1;
              errd = 1'b1;
              ph = nlrd_pkg::PH_DISCARD;
            end else if (len == 0) begin
              outs[n] = make_result(nlrd_pkg::KIND_EMPTY, 8'd0, 1'b0, 1'b0, 32'd0, start,
                                    nlrd_pkg::ERR_NONE);
              n = n + 1;
              if (grp_left == 0) ph = nlrd_pkg::PH_HEADER;
            end else begin
              row_len   = len;
              row_left  = len;
              row_start = start;
              ph = nlrd_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      nlrd_pkg::PH_PAYLOAD: begin
        outs[n] = make_result(nlrd_pkg::KIND_DATA, b, row_left == row_len, row_left == 1,
                              row_len, row_start, nlrd_pkg::ERR_NONE);
        n = n + 1;
        row_left = row_left - 1;
        grp_left = grp_left - 1;
        if (row_left == 0) ph = (grp_left == 0) ? nlrd_pkg::PH_HEADER : nlrd_pkg::PH_LENGTH;
      end
      default: ;
    endcase
    page_off = page_off + 1;

    // Page end: flag truncation unless already in error or at a group boundary
    if (is_last) begin
      clean = (ph == nlrd_pkg::PH_HEADER && fcnt == 0) || ph == nlrd_pkg::PH_DISCARD;
      if (!clean && !errd) begin
        outs[n] = make_result(nlrd_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, 32'd0, 32'd0,
                              nlrd_pkg::ERR_TRUNC);
        n = n + 1;
      end
      if (n > 0) outs[n-1].page_done = 1'b1;
      reset_deframer();
    end
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // Send one byte; the sender runs in bursts with random gaps between them
  task automatic push_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 3) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    deframe_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Page assembly helpers
  task automatic add_header(input logic [31:0] size);
    for (int i = 0; i < 4; i++) page_buf.push_back(size[8*i +: 8]);
    for (int i = 4; i < nlrd_pkg::HEADER_BYTES; i++) page_buf.push_back(8'($urandom));
  endtask

  task automatic add_len(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) page_buf.push_back(len[8*i +: 8]);
  endtask

  task automatic add_junk(input int count);
    repeat (count) page_buf.push_back(8'($urandom));
  endtask

  task automatic add_row(input int len);
    add_len(32'(len));
    add_junk(len);
  endtask

  task automatic send_page();
    for (int i = 0; i < page_buf.size(); i++)
      push_byte(page_buf[i], i == page_buf.size() - 1);
    page_buf.delete();
  endtask

  function automatic int pick_row_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(16, 64);
    return $urandom_range(0, 6);
  endfunction

  // Mostly well-formed groups with random content; some broken on purpose
  task automatic build_random_page();
    int lens[$];
    int groups;
    int size;
    int pick;
    int k;
    logic [31:0] big;
    if ($urandom_range(0, 19) == 0) begin
      add_junk($urandom_range(1, 12));
      return;
    end
    groups = $urandom_range(1, 3);
    for (int g = 0; g < groups; g++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // negative group size, then bytes to be discarded
        add_header({1'b1, 31'($urandom)});
        add_junk($urandom_range(0, 5));
        break;
      end
      if (pick < 12) begin
        add_header(32'd0);
        continue;
      end
      lens.delete();
      size = 0;
      repeat ($urandom_range(0, 4)) begin
        lens.push_back(pick_row_len());
        size += 4 + lens[$];
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // row length that overruns the group
        k = $urandom_range(0, 8);
        big = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'(k + 1 + $urandom_range(0, 1000));
        add_header(32'(size + 4 + k));
        foreach (lens[i]) add_row(lens[i]);
        add_len(big);
        add_junk(k);
        break;
      end
      if (pick < 15) begin
        // too few bytes left in the group for a length field
        k = $urandom_range(1, 3);
        add_header(32'(size + k));
        foreach (lens[i]) add_row(lens[i]);
        add_junk(k);
        break;
      end
      add_header(32'(size));
      foreach (lens[i]) add_row(lens[i]);
    end
    // truncated page
    if ($urandom_range(0, 9) == 0 && page_buf.size() > 1) begin
      k = $urandom_range(1, page_buf.size() - 1);
      repeat (k) void'(page_buf.pop_back());
    end
  endtask

  // Test: special cases and field extremes
  task automatic test_directed();
    // empty row, then a length field that cannot fit
    add_header(32'd6);
    add_row(0);
    page_buf.push_back(8'hFF);
    send_page();
    // negative group size on the header's last byte
    add_header(32'h8000_0000);
    send_page();
    // page ends inside a header
    page_buf.push_back(8'hFF);
    send_page();
    // single one-byte row closing the page cleanly
    add_header(32'd5);
    add_len(32'd1);
    page_buf.push_back(8'h00);
    send_page();
  endtask

  task automatic test_random_pages(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_random_page();
      send_page();
    end
  endtask

  // Test: receiver holds off while a long page is offered
  task automatic test_output_hold();
    hold_request = 120;
    add_header(32'd68);
    add_row(30);
    add_row(30);
    send_page();
  endtask

  // Test: sender idles until every result has come out
  task automatic test_drain_pause();
    release_input();
    while (due_results.size() != 0) @(posedge clk);
    build_random_page();
    send_page();
  endtask

  // Receiver: stall pattern that changes mode now and then, plus long holds
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rx_tick == 0) rx_mode = $urandom_range(0, 3);
    rx_tick = (rx_tick + 1) % 48;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= rx_tick[0];
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result tuser %0h tdata %0h",
                                  out_tuser, out_tdata));
      end else begin
        want = due_results.pop_front();
        check_field("kind",       32'(out_tuser[1:0]),    32'(want.kind));
        check_field("payload",    32'(out_tdata[7:0]),    32'(want.payload));
        check_field("row_first",  32'(out_tuser[2]),      32'(want.row_first));
        check_field("row_last",   32'(out_tuser[3]),      32'(want.row_last));
        check_field("row_length", out_tdata[39:8],        want.row_length);
        check_field("row_offset", out_tdata[71:40],       want.row_offset);
        check_field("error_code", 32'(out_tdata[74:72]),  32'(want.error_code));
        check_field("page_done",  32'(out_tlast),         32'(want.page_done));
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Test sequence
  initial begin
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    reset_deframer();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_pages(150);
    test_output_hold();
    test_drain_pause();
    test_random_pages(150);

    release_input();
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/nlrd_pkg.sv
rtl/nlrd_front.sv
rtl/nlrd_queue.sv
rtl/nlrd_back.sv
rtl/nested_length_prefixed_row_deframer_unit.sv
tb/tb_nested_length_prefixed_row_deframer_unit.sv
